[sv/slfr_pkg.sv]
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared constants, status codes and the controller/datapath link types
// for the sync/length framed byte receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

    localparam int          MAX_BODY_DEF = 60;
    localparam int          IDX_W        = 6;
    localparam int          HDR_BYTES    = 6;
    localparam int          PAY_MIN      = 9;
    localparam logic [7:0]  SYNC_RESET   = 8'h55;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_LEN_FAIL = 2'd1;
    localparam status_t ST_HDR_FAIL = 2'd2;
    localparam status_t ST_PAY_FAIL = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic len_load;
        logic body_wr;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_en;
        logic err_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    sync_hit;
        logic    len_ok;
        logic    body_done;
        status_t trail_status;
        logic    last;
    } stat_t;

endpackage

[sv/slfr_ctrl.sv]
// ----------------------------------------------------------------------------
// slfr_ctrl
// Frame receive sequencer: hunt, length, body, trailing length, then
// playback of the stored body or a single error result.
// ----------------------------------------------------------------------------
module slfr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  slfr_pkg::stat_t stat,
    output slfr_pkg::cmd_t  cmd
);
    import slfr_pkg::*;

    typedef enum logic [2:0] {
        S_HUNT,
        S_LEN,
        S_BODY,
        S_TRAIL,
        S_RD,
        S_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;

    assign in_fire   = in_valid && in_ready_reg;
    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_HUNT:
            begin
                if (in_fire && stat.sync_hit)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                if (in_fire)
                begin
                    if (stat.len_ok)
                    begin
                        cmd.len_load = 1'b1;
                        state_next   = S_BODY;
                    end
                    else
                        state_next = S_HUNT;
                end
            end
            S_BODY:
            begin
                if (in_fire)
                begin
                    cmd.body_wr = 1'b1;
                    if (stat.body_done)
                        state_next = S_TRAIL;
                end
            end
            S_TRAIL:
            begin
                if (in_fire)
                begin
                    if (stat.trail_status == ST_OK)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_RD;
                    end
                    else
                    begin
                        cmd.err_load = 1'b1;
                        state_next   = S_SHOW;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_ready)
                begin
                    if (stat.last)
                        state_next = S_HUNT;
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            default: state_next = S_HUNT;
        endcase
    end

    always_comb
    begin
        in_ready_next  = (state_next == S_HUNT) || (state_next == S_LEN) ||
                         (state_next == S_BODY) || (state_next == S_TRAIL);
        out_valid_next = (state_next == S_SHOW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_HUNT;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/slfr_dp.sv]
// ----------------------------------------------------------------------------
// slfr_dp
// Datapath: sync register, length and count, running XOR checks, body
// store and the registered result fields.
// ----------------------------------------------------------------------------
module slfr_dp
#(
    parameter int MAX_BODY = slfr_pkg::MAX_BODY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata,
    input  logic [7:0]                    rx_byte,
    input  slfr_pkg::cmd_t                cmd,
    output slfr_pkg::stat_t               stat,
    output slfr_pkg::status_t             status,
    output logic [7:0]                    out_byte,
    output logic [slfr_pkg::IDX_W-1:0]    byte_index,
    output logic                          last_flag
);
    import slfr_pkg::*;

    localparam int AW = $clog2(MAX_BODY);

    logic [7:0]       sync_reg;
    logic [IDX_W-1:0] len_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [7:0]       hdr_acc_reg;
    logic [7:0]       pay_acc_reg;
    logic [7:0]       rd_data_reg;
    status_t          status_reg;
    logic             last_reg;
    logic [7:0]       mem [MAX_BODY];

    logic [IDX_W:0]   cnt_plus1;
    status_t          trail_status;

    assign cnt_plus1 = {1'b0, cnt_reg} + (IDX_W+1)'(1);

    // both accumulators cover their check byte, so a good frame leaves zero
    always_comb
    begin
        if (rx_byte != {{(8-IDX_W){1'b0}}, len_reg})
            trail_status = ST_LEN_FAIL;
        else if (len_reg < IDX_W'(HDR_BYTES + 1))
            trail_status = ST_HDR_FAIL;
        else if (hdr_acc_reg != 8'd0)
            trail_status = ST_HDR_FAIL;
        else if ((len_reg >= IDX_W'(PAY_MIN)) && (pay_acc_reg != 8'd0))
            trail_status = ST_PAY_FAIL;
        else
            trail_status = ST_OK;
    end

    always_comb
    begin
        stat.sync_hit     = (rx_byte == sync_reg);
        stat.len_ok       = (rx_byte != 8'd0) && (rx_byte <= 8'(MAX_BODY));
        stat.body_done    = (cnt_plus1 >= {1'b0, len_reg});
        stat.trail_status = trail_status;
        stat.last         = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
            len_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                sync_reg <= cfg_wdata;
            if (cmd.len_load)
                len_reg <= rx_byte[IDX_W-1:0];
            if (cmd.len_load || cmd.cnt_clr || cmd.err_load)
                cnt_reg <= '0;
            else if (cmd.body_wr || cmd.cnt_inc)
                cnt_reg <= cnt_plus1[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.len_load)
        begin
            hdr_acc_reg <= 8'd0;
            pay_acc_reg <= 8'd0;
        end
        else if (cmd.body_wr)
        begin
            if (cnt_reg <= IDX_W'(HDR_BYTES))
                hdr_acc_reg <= hdr_acc_reg ^ rx_byte;
            else
                pay_acc_reg <= pay_acc_reg ^ rx_byte;
        end

        if (cmd.rd_en)
        begin
            status_reg <= ST_OK;
            last_reg   <= (cnt_plus1 == {1'b0, len_reg});
        end
        else if (cmd.err_load)
        begin
            status_reg <= trail_status;
            last_reg   <= 1'b1;
        end
    end

    // body store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.body_wr)
            mem[cnt_reg[AW-1:0]] <= rx_byte;
        if (cmd.rd_en)
            rd_data_reg <= mem[cnt_reg[AW-1:0]];
        else if (cmd.err_load)
            rd_data_reg <= 8'd0;
    end

    assign status     = status_reg;
    assign out_byte   = rd_data_reg;
    assign byte_index = cnt_reg;
    assign last_flag  = last_reg;

endmodule

[sv/sync_length_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Hunts for a sync byte, takes a length and body, checks the trailing
// length and the XOR checks, then plays the body out or reports an error.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  in      | in_valid/in_ready, rx_byte       | one received byte per transfer
//  out     | out_valid/out_ready, status,     | one body byte or one error
//          | out_byte, byte_index, last_flag  | result per transfer
//  cfg     | cfg_we, cfg_wdata                | sync byte value, no wait
//
//  Received bytes are taken back to back; checks run as the body arrives.
//  A good frame plays back each byte as a registered store read, then the
//  result, and output stalls can hold it; an error is a single result.
//  No byte is taken while results are being delivered.
//  Reset: hunting for sync, sync value 0x55; the store needs no clearing.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver
#(
    parameter int MAX_BODY = slfr_pkg::MAX_BODY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output slfr_pkg::status_t          status,
    output logic [7:0]                 out_byte,
    output logic [slfr_pkg::IDX_W-1:0] byte_index,
    output logic                       last_flag
);
    import slfr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    slfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    slfr_dp #(.MAX_BODY(MAX_BODY)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .stat       (stat),
        .status     (status),
        .out_byte   (out_byte),
        .byte_index (byte_index),
        .last_flag  (last_flag)
    );

endmodule

[sv/slfr_checker.sv]
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  slfr_pkg::status_t          status,
    input  logic [7:0]                 out_byte,
    input  logic [slfr_pkg::IDX_W-1:0] byte_index,
    input  logic                       last_flag
);
    import slfr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(status) && $stable(byte_index) && $stable(last_flag))
        else $error("result changed while stalled");

    // no byte taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during delivery");

    // error result is a single flagged, zeroed transfer
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
        last_flag && (out_byte == 8'd0) && (byte_index == '0))
        else $error("malformed error result");

    // next body byte follows in order after a gap for the store read
    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_flag |=>
        !out_valid ##1 out_valid && (byte_index == $past(byte_index, 2) + 1'b1))
        else $error("body index out of sequence");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_byte   (out_byte),
    .byte_index (byte_index),
    .last_flag  (last_flag)
);

[test/sync_length_frame_checker.sv]
// ----------------------------------------------------------------------------
// sync_length_frame_checker
// Watches the byte, result and sync-register ports of the frame receiver,
// predicts every result from the accepted bytes and compares each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sync_length_frame_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  slfr_pkg::status_t          status,
    input  logic [7:0]                 out_byte,
    input  logic [slfr_pkg::IDX_W-1:0] byte_index,
    input  logic                       last_flag,
    output int                         fail_count,
    output int                         results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BODY_MAX = slfr_pkg::MAX_BODY_DEF;

    typedef enum logic [1:0] {RX_HUNT, RX_LEN, RX_BODY, RX_TRAIL} rx_phase_t;

    typedef struct packed {
        slfr_pkg::status_t          st;
        logic [7:0]                 data;
        logic [slfr_pkg::IDX_W-1:0] idx;
        logic                       is_last;
    } frame_result_t;

    rx_phase_t     rx_phase;
    logic [7:0]    sync_byte;
    logic [5:0]    body_len;
    logic [5:0]    body_count;
    logic [7:0]    body_bytes [0:BODY_MAX-1];
    frame_result_t results_q [$];

    // header XOR over bytes 0..5 against byte 6, then payload XOR for long bodies
    function automatic slfr_pkg::status_t frame_verdict();
        logic [7:0] acc;
        int         i;
        if (body_len < slfr_pkg::HDR_BYTES + 1)
            return slfr_pkg::ST_HDR_FAIL;
        acc = 8'd0;
        for (i = 0; i < slfr_pkg::HDR_BYTES; i++)
            acc ^= body_bytes[i];
        if (acc != body_bytes[slfr_pkg::HDR_BYTES])
            return slfr_pkg::ST_HDR_FAIL;
        if (body_len >= slfr_pkg::PAY_MIN)
        begin
            acc = 8'd0;
            for (i = slfr_pkg::HDR_BYTES + 1; i < int'(body_len) - 1; i++)
                acc ^= body_bytes[i];
            if (acc != body_bytes[body_len - 6'd1])
                return slfr_pkg::ST_PAY_FAIL;
        end
        return slfr_pkg::ST_OK;
    endfunction

    task automatic push_error(input slfr_pkg::status_t st);
        frame_result_t r;
        r.st      = st;
        r.data    = 8'd0;
        r.idx     = '0;
        r.is_last = 1'b1;
        results_q.push_back(r);
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        frame_result_t     r;
        slfr_pkg::status_t verdict;
        int                i;
        case (rx_phase)
            RX_HUNT:
            begin
                if (b == sync_byte)
                    rx_phase = RX_LEN;
            end
            RX_LEN:
            begin
                if (b >= 8'd1 && b <= BODY_MAX)
                begin
                    body_len   = b[5:0];
                    body_count = 6'd0;
                    rx_phase   = RX_BODY;
                end
                else
                    rx_phase = RX_HUNT;
            end
            RX_BODY:
            begin
                if (body_count < BODY_MAX)
                begin
                    body_bytes[body_count] = b;
                    body_count++;
                end
                if (body_count >= body_len)
                    rx_phase = RX_TRAIL;
            end
            default:
            begin
                rx_phase = RX_HUNT;
                if (b != {2'b00, body_len})
                    push_error(slfr_pkg::ST_LEN_FAIL);
                else
                begin
                    verdict = frame_verdict();
                    if (verdict != slfr_pkg::ST_OK)
                        push_error(verdict);
                    else
                    begin
                        for (i = 0; i < int'(body_len); i++)
                        begin
                            r.st      = slfr_pkg::ST_OK;
                            r.data    = body_bytes[i];
                            r.idx     = i[slfr_pkg::IDX_W-1:0];
                            r.is_last = (i + 1 == int'(body_len));
                            results_q.push_back(r);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_result();
        frame_result_t want;
        if (results_q.size() == 0)
        begin
            $error("result with nothing pending: status %0d out_byte %0h byte_index %0d last_flag %0b",
                   status, out_byte, byte_index, last_flag);
            fail_count++;
        end
        else
        begin
            want = results_q.pop_front();
            if (status !== want.st)
            begin
                $error("status: expected %0d, got %0d", want.st, status);
                fail_count++;
            end
            if (out_byte !== want.data)
            begin
                $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                fail_count++;
            end
            if (byte_index !== want.idx)
            begin
                $error("byte_index: expected %0d, got %0d", want.idx, byte_index);
                fail_count++;
            end
            if (last_flag !== want.is_last)
            begin
                $error("last_flag: expected %0b, got %0b", want.is_last, last_flag);
                fail_count++;
            end
        end
    endtask

    // results first: a byte accepted on this edge cannot produce one yet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase   = RX_HUNT;
            sync_byte  = slfr_pkg::SYNC_RESET;
            body_len   = 6'd0;
            body_count = 6'd0;
            results_q.delete();
            results_due = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_we)
                sync_byte = cfg_wdata;
            if (in_valid && in_ready)
                take_rx_byte(rx_byte);
            results_due = results_q.size();
        end
    end

endmodule

[test/sync_length_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_tb
// Drives framed byte streams (good frames, corrupted checks, bad lengths,
// truncated frames and line noise) under several sync values, with random
// idling on both channels and one long result hold-off; a checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 66;

    typedef enum {FAULT_NONE, FAULT_TRAIL, FAULT_HDR, FAULT_PAY} frame_fault_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [7:0]                 cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic [7:0]                 rx_byte;
    logic                       out_valid;
    logic                       out_ready;
    slfr_pkg::status_t          status;
    logic [7:0]                 out_byte;
    logic [slfr_pkg::IDX_W-1:0] byte_index;
    logic                       last_flag;

    int         fail_count;
    int         results_due;
    int         cycle_count;
    int         frame_items;
    bit         idle_on;
    bit         hold_req;
    logic [7:0] cur_sync;
    logic [7:0] frame_body [0:63];

    sync_length_frame_receiver DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_byte   (out_byte),
        .byte_index (byte_index),
        .last_flag  (last_flag)
    );

    sync_length_frame_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_byte    (out_byte),
        .byte_index  (byte_index),
        .last_flag   (last_flag),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // result side: random back-pressure, plus one long hold when requested
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // valid is left high on return; the caller's next step decides
    task automatic push_rx(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_sync = v;
    endtask

    // sync, length, body with valid XOR checks, trailing length; at most one fault applied
    task automatic send_frame(input int len, input frame_fault_t fault);
        logic [7:0] acc;
        logic [7:0] trail;
        int         i;
        int         pos;
        for (i = 0; i < len; i++)
            frame_body[i] = ($urandom_range(0, 7) == 0) ? cur_sync : 8'($urandom_range(0, 255));
        if (len >= slfr_pkg::HDR_BYTES + 1)
        begin
            acc = 8'd0;
            for (i = 0; i < slfr_pkg::HDR_BYTES; i++)
                acc ^= frame_body[i];
            frame_body[slfr_pkg::HDR_BYTES] = acc;
        end
        if (len >= slfr_pkg::PAY_MIN)
        begin
            acc = 8'd0;
            for (i = slfr_pkg::HDR_BYTES + 1; i < len - 1; i++)
                acc ^= frame_body[i];
            frame_body[len-1] = acc;
        end
        trail = 8'(len);
        case (fault)
            FAULT_TRAIL:
                trail = 8'(len) ^ (8'd1 << $urandom_range(0, 7));
            FAULT_HDR:
            begin
                if (len >= slfr_pkg::HDR_BYTES + 1)
                begin
                    pos = $urandom_range(0, slfr_pkg::HDR_BYTES);
                    frame_body[pos] ^= 8'd1 << $urandom_range(0, 7);
                end
            end
            FAULT_PAY:
            begin
                if (len >= slfr_pkg::PAY_MIN)
                begin
                    pos = $urandom_range(slfr_pkg::HDR_BYTES + 1, len - 1);
                    frame_body[pos] ^= 8'd1 << $urandom_range(0, 7);
                end
            end
            default:
                ;
        endcase
        push_rx(cur_sync);
        push_rx(8'(len));
        for (i = 0; i < len; i++)
            push_rx(frame_body[i]);
        push_rx(trail);
        frame_items += len + 3;
    endtask

    task automatic random_chunk();
        int           r;
        int           n;
        int           i;
        int           len;
        frame_fault_t fault;
        r = $urandom_range(0, 29);
        if (r == 0)
        begin
            // line noise, mostly ignored in the hunt
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                push_rx(8'($urandom_range(0, 255)));
        end
        else if (r == 1)
        begin
            push_rx(cur_sync);
            push_rx(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(61, 255)));
            frame_items += 2;
        end
        else if (r == 2)
        begin
            // truncated frame: following bytes land in the body
            len = $urandom_range(1, 8);
            n   = $urandom_range(0, len - 1);
            push_rx(cur_sync);
            push_rx(8'(len));
            for (i = 0; i < n; i++)
                push_rx(8'($urandom_range(0, 255)));
            frame_items += n + 2;
        end
        else
        begin
            if (r == 3)
                len = slfr_pkg::MAX_BODY_DEF;
            else if (r == 4)
                len = $urandom_range(17, 59);
            else
                len = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                6:       fault = FAULT_TRAIL;
                7:       fault = FAULT_HDR;
                8:       fault = FAULT_PAY;
                default: fault = FAULT_NONE;
            endcase
            send_frame(len, fault);
        end
    endtask

    initial
    begin
        int p;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 8'd0;
        in_valid    = 1'b0;
        rx_byte     = 8'd0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        cur_sync    = slfr_pkg::SYNC_RESET;
        frame_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // bad lengths at both edges, short body, header-only body, payload failure
        push_rx(cur_sync);
        push_rx(8'd0);
        push_rx(cur_sync);
        push_rx(8'd61);
        send_frame(1, FAULT_NONE);
        send_frame(7, FAULT_NONE);
        send_frame(9, FAULT_PAY);

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:       write_sync(8'h00);
                1:       write_sync(8'hFF);
                2:       write_sync(8'($urandom_range(0, 255)));
                3:       write_sync(8'd42);   // sync value that is also a legal length
                default: write_sync(slfr_pkg::SYNC_RESET);
            endcase
            frame_items = 0;
            if (p == 4)
                idle_on = 1'b0;
            if (p == 1)
            begin
                hold_req = 1'b1;
                send_frame(slfr_pkg::MAX_BODY_DEF, FAULT_NONE);
            end
            while (frame_items < PHASE_ITEMS)
                random_chunk();
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
sv/slfr_pkg.sv
sv/slfr_ctrl.sv
sv/slfr_dp.sv
sv/sync_length_frame_receiver.sv
sv/slfr_checker.sv
test/sync_length_frame_checker.sv
test/sync_length_frame_receiver_tb.sv
